>>> rtl/grt_pkg.sv
// Shared types, codes and character constants of the grammar rule tokenizer.
package grt_pkg;

    // Token kinds as they leave the block
    typedef enum logic [3:0] {
        K_ARROW  = 4'd0,
        K_BAR    = 4'd1,
        K_SEMI   = 4'd2,
        K_STRING = 4'd3,
        K_IDENT  = 4'd4,
        K_EPS    = 4'd5,
        K_END    = 4'd6,
        K_BAD    = 4'd7,
        K_UNTERM = 4'd8
    } t_kind;

    localparam int TOKEN_WIDTH = 16;

    // One result token
    typedef struct packed {
        t_kind                  kind;
        logic [TOKEN_WIDTH-1:0] start;
        logic [TOKEN_WIDTH-1:0] length;
        logic                   last;
    } t_token;

    // Tokens produced by one accepted request, at most two
    typedef struct packed {
        logic [1:0] count;
        t_token     tok_a;
        t_token     tok_b;
    } t_scan_out;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Punctuation bytes
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Length of the keyword "epsilon"
    localparam logic [2:0] KW_LEN = 3'd7;

    // Character of the keyword at a given position
    function automatic logic [7:0] f_kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h65; // e
            3'd1:    ch = 8'h70; // p
            3'd2:    ch = 8'h73; // s
            3'd3:    ch = 8'h69; // i
            3'd4:    ch = 8'h6C; // l
            3'd5:    ch = 8'h6F; // o
            3'd6:    ch = 8'h6E; // n
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/grt_ifs.sv
// Valid/ready channel interfaces for text bytes and result tokens.
interface grt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
    modport monitor (input valid, input ready, input text_byte, input end_of_text);
endinterface

interface grt_token_if;
    logic          valid;
    logic          ready;
    grt_pkg::t_kind token_kind;
    logic [15:0]   token_start;
    logic [15:0]   token_length;
    logic          last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
    modport monitor (input valid, input ready, input token_kind, input token_start,
                     input token_length, input last_of_run);
endinterface

>>> rtl/grammar_rule_tokenizer.sv
// Top level of the grammar rule tokenizer.
// Usage:
//   i_text carries one text byte per request, or an end marker with
//   end_of_text high (its byte is ignored). o_tok carries tokens as kind,
//   start offset and length; last_of_run flags the final token of a request.
//   Each accepted request's tokens are written into the result queue
//   and o_tok offers the queue head. Throughput: one request per cycle
//   while i_text.ready is high; a request that yields two tokens
//   (identifier closed by a bar, semicolon or invalid byte, or a pending
//   lexeme at the end marker) is absorbed by the four-entry result queue.
//   i_text.ready is high while the queue has room for two tokens, so it
//   holds across a stalled receiver until three tokens wait. Reset: the
//   scanner idles at offset zero, the queue empties, i_text.ready is high.
//   A stalled receiver holds the head token steady; once the queue holds
//   three or more tokens, i_text.ready drops until tokens drain.
module grammar_rule_tokenizer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grt_byte_if.sink    i_text,
    grt_token_if.source o_tok
);
    import grt_pkg::*;

    logic      w_accept;
    logic      w_space;
    logic      w_out_valid;
    t_scan_out w_scan;
    t_token    w_head;

    assign i_text.ready = w_space;
    assign w_accept     = i_text.valid && w_space;

    grt_scanner #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scanner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_text_byte   (i_text.text_byte),
        .i_end_of_text (i_text.end_of_text),
        .o_scan        (w_scan)
    );

    grt_result_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_accept ? w_scan.count : 2'd0),
        .i_tok_a      (w_scan.tok_a),
        .i_tok_b      (w_scan.tok_b),
        .o_space      (w_space),
        .o_valid      (w_out_valid),
        .o_tok        (w_head),
        .i_pop        (o_tok.ready)
    );

    // Drive the token channel from the queue head
    assign o_tok.valid        = w_out_valid;
    assign o_tok.token_kind   = w_head.kind;
    assign o_tok.token_start  = w_head.start;
    assign o_tok.token_length = w_head.length;
    assign o_tok.last_of_run  = w_head.last;

endmodule

>>> rtl/grt_scanner.sv
// Scanner state and token decode for one text byte or end marker.
module grt_scanner #(
    parameter int OFFSET_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_text_byte,
    input  logic               i_end_of_text,
    output grt_pkg::t_scan_out o_scan
);
    import grt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DASH   = 5'b00010,
        S_STRING = 5'b00100,
        S_IDENT  = 5'b01000,
        S_ERROR  = 5'b10000
    } t_mode;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_lstart, n_lstart;
    logic [2:0]             r_kidx, n_kidx;
    logic                   r_kmatch, n_kmatch;

    t_mode                  f_mode;
    logic [OFFSET_BITS-1:0] f_lstart;
    logic [2:0]             f_kidx;
    logic                   f_kmatch;
    logic                   f_emit;
    t_token                 f_tok;

    logic [OFFSET_BITS-1:0] w_span;
    t_token                 w_id_tok;
    t_token                 w_end_tok;
    t_scan_out              w_scan;

    function automatic logic f_is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic f_is_word(input logic [7:0] b);
        return f_is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDER);
    endfunction

    // Fit an offset to the token field width
    function automatic logic [TOKEN_WIDTH-1:0] f_to_field(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+TOKEN_WIDTH-1:0] w;
        w = {{TOKEN_WIDTH{1'b0}}, v};
        return w[TOKEN_WIDTH-1:0];
    endfunction

    function automatic t_token f_make(input t_kind k, input logic [TOKEN_WIDTH-1:0] s,
                                      input logic [TOKEN_WIDTH-1:0] l);
        t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.last   = 1'b0;
        return t;
    endfunction

    // Length of the pending lexeme, floored at zero
    assign w_span = (r_off >= r_lstart) ? (r_off - r_lstart) : '0;

    assign w_id_tok = f_make((r_kmatch && r_kidx == KW_LEN) ? K_EPS : K_IDENT,
                             f_to_field(r_lstart), f_to_field(w_span));
    assign w_end_tok = f_make(K_END, f_to_field(r_off), '0);

    // Decode a byte as the first byte of a new token
    always_comb begin
        f_mode   = S_IDLE;
        f_lstart = r_lstart;
        f_kidx   = r_kidx;
        f_kmatch = r_kmatch;
        f_emit   = 1'b0;
        f_tok    = f_make(K_BAD, f_to_field(r_off), '0);
        if (f_is_space(i_text_byte)) begin
            f_mode = S_IDLE;
        end else if (i_text_byte == CH_DASH) begin
            f_mode   = S_DASH;
            f_lstart = r_off;
        end else if (i_text_byte == CH_BAR) begin
            f_emit = 1'b1;
            f_tok  = f_make(K_BAR, f_to_field(r_off), TOKEN_WIDTH'(1));
        end else if (i_text_byte == CH_SEMI) begin
            f_emit = 1'b1;
            f_tok  = f_make(K_SEMI, f_to_field(r_off), TOKEN_WIDTH'(1));
        end else if (i_text_byte == CH_QUOTE) begin
            f_mode   = S_STRING;
            f_lstart = (r_off < OFFSET_MAX) ? (r_off + 1'b1) : OFFSET_MAX;
        end else if (f_is_alpha(i_text_byte) || i_text_byte == CH_UNDER) begin
            f_mode   = S_IDENT;
            f_lstart = r_off;
            f_kmatch = (i_text_byte == f_kw_char(3'd0));
            f_kidx   = {2'b00, f_kmatch};
        end else begin
            f_mode = S_ERROR;
            f_emit = 1'b1;
        end
    end

    // Step the scanner and collect the tokens of this request
    always_comb begin
        n_mode       = r_mode;
        n_off        = r_off;
        n_lstart     = r_lstart;
        n_kidx       = r_kidx;
        n_kmatch     = r_kmatch;
        w_scan.count = 2'd0;
        w_scan.tok_a = w_end_tok;
        w_scan.tok_b = w_end_tok;
        if (i_end_of_text) begin
            // Flush the pending lexeme, then close the text
            w_scan.count = 2'd2;
            case (r_mode)
                S_IDENT:  w_scan.tok_a = w_id_tok;
                S_STRING: w_scan.tok_a = f_make(K_UNTERM, f_to_field(r_lstart),
                                                f_to_field(w_span));
                S_DASH:   w_scan.tok_a = f_make(K_BAD, f_to_field(r_lstart), '0);
                default:  w_scan.count = 2'd1;
            endcase
            n_mode   = S_IDLE;
            n_off    = '0;
            n_lstart = '0;
            n_kidx   = '0;
            n_kmatch = 1'b1;
        end else begin
            case (r_mode)
                S_IDLE: begin
                    n_mode       = f_mode;
                    n_lstart     = f_lstart;
                    n_kidx       = f_kidx;
                    n_kmatch     = f_kmatch;
                    w_scan.count = {1'b0, f_emit};
                    w_scan.tok_a = f_tok;
                end
                S_DASH: begin
                    w_scan.count = 2'd1;
                    if (i_text_byte == CH_GT) begin
                        n_mode       = S_IDLE;
                        w_scan.tok_a = f_make(K_ARROW, f_to_field(r_lstart), TOKEN_WIDTH'(2));
                    end else begin
                        n_mode       = S_ERROR;
                        w_scan.tok_a = f_make(K_BAD, f_to_field(r_lstart), '0);
                    end
                end
                S_STRING: begin
                    if (i_text_byte == CH_QUOTE) begin
                        n_mode       = S_IDLE;
                        w_scan.count = 2'd1;
                        w_scan.tok_a = f_make(K_STRING, f_to_field(r_lstart),
                                              f_to_field(w_span));
                    end
                end
                S_IDENT: begin
                    if (f_is_word(i_text_byte)) begin
                        // Track the keyword match
                        if (r_kmatch && r_kidx < KW_LEN && i_text_byte == f_kw_char(r_kidx)) begin
                            n_kidx = r_kidx + 3'd1;
                        end else begin
                            n_kmatch = 1'b0;
                        end
                    end else begin
                        // Close the identifier and rescan the ending byte
                        n_mode       = f_mode;
                        n_lstart     = f_lstart;
                        n_kidx       = f_kidx;
                        n_kmatch     = f_kmatch;
                        w_scan.tok_a = w_id_tok;
                        w_scan.tok_b = f_tok;
                        w_scan.count = f_emit ? 2'd2 : 2'd1;
                    end
                end
                S_ERROR: begin
                    n_mode = S_ERROR;
                end
                default: begin
                    n_mode = S_ERROR;
                end
            endcase
            if (r_off < OFFSET_MAX) begin
                n_off = r_off + 1'b1;
            end
        end
        // Mark the final token of the request
        w_scan.tok_a.last = (w_scan.count == 2'd1);
        w_scan.tok_b.last = 1'b1;
    end

    assign o_scan = w_scan;

    // Advance state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_IDLE;
            r_off    <= '0;
            r_lstart <= '0;
            r_kidx   <= '0;
            r_kmatch <= 1'b1;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_off    <= n_off;
            r_lstart <= n_lstart;
            r_kidx   <= n_kidx;
            r_kmatch <= n_kmatch;
        end
    end

endmodule

>>> rtl/grt_result_queue.sv
// Four-entry token queue that takes up to two tokens per cycle.
module grt_result_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_count,
    input  grt_pkg::t_token    i_tok_a,
    input  grt_pkg::t_token    i_tok_b,
    output logic               o_space,
    output logic               o_valid,
    output grt_pkg::t_token    o_tok,
    input  logic               i_pop
);
    import grt_pkg::*;

    t_token                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, n_wr;
    logic [QUEUE_PTR_W-1:0] r_rd, n_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt, n_cnt;
    logic                   w_pop;

    // Room for a full request of two tokens
    assign o_space = (r_cnt <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign w_pop   = o_valid && i_pop;

    always_comb begin
        n_wr  = r_wr + QUEUE_PTR_W'(i_push_count);
        n_rd  = r_rd + QUEUE_PTR_W'(w_pop);
        n_cnt = r_cnt + QUEUE_CNT_W'(i_push_count) - QUEUE_CNT_W'(w_pop);
    end

    // Write the pushed tokens in order
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_tok_a;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr + QUEUE_PTR_W'(1)] <= i_tok_b;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/grt_checker.sv
// Port-level checks of the grammar rule tokenizer, bound to the top level.
module grt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_text_valid,
    input logic           i_text_ready,
    input logic           i_text_end,
    input logic           i_tok_valid,
    input logic           i_tok_ready,
    input grt_pkg::t_kind i_tok_kind,
    input logic           i_tok_last
);
    import grt_pkg::*;

    // Hold an offered token until it is taken
    a_tok_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok_valid && !i_tok_ready) |=> i_tok_valid)
        else $error("token dropped before it was taken");

    // Come out of reset ready for a request
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_text_ready)
        else $error("input not ready after reset");

    // An empty output side always takes requests
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tok_valid |-> i_text_ready)
        else $error("input stalled with no token pending");

    // An end marker always yields a token
    a_end_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_text_valid && i_text_ready && i_text_end) |=> i_tok_valid)
        else $error("end marker produced no token");

    // The end token closes its request
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok_valid && i_tok_kind == K_END) |-> i_tok_last)
        else $error("end token not flagged last");

endmodule

bind grammar_rule_tokenizer grt_checker u_grt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_text_valid (i_text.valid),
    .i_text_ready (i_text.ready),
    .i_text_end   (i_text.end_of_text),
    .i_tok_valid  (o_tok.valid),
    .i_tok_ready  (o_tok.ready),
    .i_tok_kind   (o_tok.token_kind),
    .i_tok_last   (o_tok.last_of_run)
);
